// File: design/baro_comp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package baro_comp_pkg;

    // port and register widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int RATIO_W = 8;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 3;
    localparam int TOUT_W  = 15;
    localparam int POUT_W  = 17;
    localparam int ERR_W   = 2;

    // datapath widths
    localparam int DT_W     = 25;
    localparam int MUL_W    = 26;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int OFF_W    = 38;
    localparam int SENS_W   = 36;
    localparam int TEMP_W   = 19;
    localparam int TCOMP_W  = 20;
    localparam int T2_W     = 18;
    localparam int ASQ_W    = 26;
    localparam int BSQ_W    = 23;
    localparam int A61_W    = 32;
    localparam int B15_W    = 27;
    localparam int OFF2_W   = 29;
    localparam int SENS2_W  = 28;
    localparam int SLO_W    = 18;
    localparam int PLO_W    = RAW_W + SLO_W;
    localparam int PSUM_W   = 61;
    localparam int PDIFF_W  = 41;
    localparam int PRESS_W  = 26;

    // scaling shifts
    localparam int OFF_BASE_SH  = 17;
    localparam int SENS_BASE_SH = 16;
    localparam int TREF_SH      = 8;
    localparam int OFF_SH       = 6;
    localparam int SENS_SH      = 7;
    localparam int TEMP_SH      = 23;
    localparam int T2_SH        = 31;
    localparam int OFF2_SH      = 4;
    localparam int PSUM_SH      = 21;
    localparam int PRESS_SH     = 15;

    // temperature and pressure limits
    localparam int T_REF  = 2000;
    localparam int T_COLD = -1500;
    localparam int T_LOW  = -4000;
    localparam int T_HIGH = 8500;
    localparam int P_HIGH = 120000;

    // measurement count wraps here
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // count modulo ratio: two restoring steps per cycle
    localparam int MOD_STEPS = 4;
    localparam int MOD_CW    = 2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_SENS     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_OFF      = 3'd1;
    localparam logic [IDX_W-1:0] CFG_TCS      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_TCO      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TREF     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TEMPSENS = 3'd5;
    localparam logic [IDX_W-1:0] CFG_RATIO    = 3'd6;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_TEMP  = 2'd1,
        ERR_PRESS = 2'd2
    } err_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MOD,
        ST_DT,
        ST_M_TCO,
        ST_M_TCS,
        ST_M_TSENS,
        ST_M_DTSQ,
        ST_M_ASQ,
        ST_M_BSQ,
        ST_CORR,
        ST_APPLY,
        ST_M_PLO,
        ST_M_PHI,
        ST_PSUM,
        ST_PDIFF,
        ST_WRITE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_TCO,
        MUL_TCS,
        MUL_TSENS,
        MUL_DTSQ,
        MUL_ASQ,
        MUL_BSQ,
        MUL_PLO,
        MUL_PHI
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_OFF,
        ACC_SENS,
        ACC_TEMP,
        ACC_T2,
        ACC_ASQ,
        ACC_PLO,
        ACC_PSUM
    } acc_op_t;

    typedef struct packed {
        logic    load;
        logic    mod_step;
        logic    dt_load;
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    corr_calc;
        logic    corr_apply;
        logic    pdiff_load;
        logic    out_load;
    } cmd_t;

endpackage

`default_nettype wire

// File: design/baro_comp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module baro_comp_ctrl
    import baro_comp_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  in_valid,
    output logic in_stall,
    output logic out_valid,
    input  wire  out_stall,
    output cmd_t cmd
);

    localparam logic [MOD_CW-1:0] MOD_LAST = MOD_CW'(MOD_STEPS - 1);

    state_t             state_reg, state_next;
    logic [MOD_CW-1:0]  mod_cnt_reg, mod_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    // output register can take a new beat
    assign out_free = !(out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_cnt_reg   <= mod_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_MOD;
            ST_MOD:     if (mod_cnt_reg == MOD_LAST) state_next = ST_DT;
            ST_DT:      state_next = ST_M_TCO;
            ST_M_TCO:   state_next = ST_M_TCS;
            ST_M_TCS:   state_next = ST_M_TSENS;
            ST_M_TSENS: state_next = ST_M_DTSQ;
            ST_M_DTSQ:  state_next = ST_M_ASQ;
            ST_M_ASQ:   state_next = ST_M_BSQ;
            ST_M_BSQ:   state_next = ST_CORR;
            ST_CORR:    state_next = ST_APPLY;
            ST_APPLY:   state_next = ST_M_PLO;
            ST_M_PLO:   state_next = ST_M_PHI;
            ST_M_PHI:   state_next = ST_PSUM;
            ST_PSUM:    state_next = ST_PDIFF;
            ST_PDIFF:   state_next = ST_WRITE;
            ST_WRITE:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mod_cnt_next = (state_reg == ST_MOD) ? mod_cnt_reg + 1'b1 : '0;
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        cmd.acc_op     = ACC_NONE;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_MOD:     cmd.mod_step = 1'b1;
            ST_DT:      cmd.dt_load = 1'b1;
            ST_M_TCO:   cmd.mul_op = MUL_TCO;
            ST_M_TCS:
            begin
                cmd.mul_op = MUL_TCS;
                cmd.acc_op = ACC_OFF;
            end
            ST_M_TSENS:
            begin
                cmd.mul_op = MUL_TSENS;
                cmd.acc_op = ACC_SENS;
            end
            ST_M_DTSQ:
            begin
                cmd.mul_op = MUL_DTSQ;
                cmd.acc_op = ACC_TEMP;
            end
            ST_M_ASQ:
            begin
                cmd.mul_op = MUL_ASQ;
                cmd.acc_op = ACC_T2;
            end
            ST_M_BSQ:
            begin
                cmd.mul_op = MUL_BSQ;
                cmd.acc_op = ACC_ASQ;
            end
            ST_CORR:    cmd.corr_calc = 1'b1;
            ST_APPLY:   cmd.corr_apply = 1'b1;
            ST_M_PLO:   cmd.mul_op = MUL_PLO;
            ST_M_PHI:
            begin
                cmd.mul_op = MUL_PHI;
                cmd.acc_op = ACC_PLO;
            end
            ST_PSUM:    cmd.acc_op = ACC_PSUM;
            ST_PDIFF:   cmd.pdiff_load = 1'b1;
            ST_WRITE:   cmd.out_load = out_free;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/baro_comp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module baro_comp_dp
    import baro_comp_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire  cmd_t                 cmd,
    input  wire                        cfg_wr_en,
    input  wire  [IDX_W-1:0]           cfg_index,
    input  wire  [COEF_W-1:0]          cfg_data,
    input  wire  [RAW_W-1:0]           raw_pressure,
    input  wire  [RAW_W-1:0]           raw_temperature,
    output logic signed [TOUT_W-1:0]   temperature,
    output logic [POUT_W-1:0]          pressure,
    output logic                       valid_res,
    output logic [ERR_W-1:0]           error_code,
    output logic                       temp_sampled
);

    // calibration and ratio
    logic [COEF_W-1:0]  sens_coef_reg, off_coef_reg, tcs_coef_reg;
    logic [COEF_W-1:0]  tco_coef_reg, tref_coef_reg, tempsens_coef_reg;
    logic [RATIO_W-1:0] temp_ratio_reg;

    // sensor state
    logic [RAW_W-1:0]   held_reg;
    logic [CNT_W-1:0]   count_reg;

    // per-item work registers
    logic [RAW_W-1:0]          d1_reg, rawt_reg;
    logic [CNT_W-1:0]          mcnt_reg;
    logic [RATIO_W-1:0]        rem_reg;
    logic                      samp_reg;
    logic signed [DT_W-1:0]    dt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [OFF_W-1:0]   off_reg;
    logic signed [SENS_W-1:0]  sens_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic [T2_W-1:0]           t2_reg;
    logic [ASQ_W-1:0]          asq_reg;
    logic [OFF2_W-1:0]         off2_reg;
    logic [SENS2_W-1:0]        sens2_reg;
    logic signed [TCOMP_W-1:0] tcomp_reg;
    logic [PLO_W-1:0]          plo_reg;
    logic signed [PSUM_W-1:0]  psum_reg;
    logic signed [PDIFF_W-1:0] pdiff_reg;

    // result beat
    logic signed [TOUT_W-1:0]  tout_reg;
    logic [POUT_W-1:0]         pout_reg;
    err_t                      err_reg;
    logic                      samp_out_reg;

    logic [RATIO_W-1:0]        ratio_eff;
    logic [RATIO_W:0]          r1, r1s, r2, r2s;
    logic                      sampled;
    logic [RAW_W-1:0]          dt_src;
    logic signed [DT_W-1:0]    dt_val;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [TCOMP_W-1:0] a_val, b_val;

    logic                      warm, cold, t_ok, p_ok;
    logic [BSQ_W-1:0]          bsq;
    logic [A61_W-1:0]          asq61;
    logic [B15_W-1:0]          bsq15;
    logic [OFF2_W-1:0]         off2_val;
    logic [SENS2_W-1:0]        sens2_val;
    logic signed [PRESS_W-1:0] press;
    logic signed [TCOMP_W-1:0] tsat;

    // config registers and sensor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_coef_reg     <= '0;
            off_coef_reg      <= '0;
            tcs_coef_reg      <= '0;
            tco_coef_reg      <= '0;
            tref_coef_reg     <= '0;
            tempsens_coef_reg <= '0;
            temp_ratio_reg    <= RATIO_W'(1);
            held_reg          <= '0;
            count_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SENS:     sens_coef_reg     <= cfg_data;
                    CFG_OFF:      off_coef_reg      <= cfg_data;
                    CFG_TCS:      tcs_coef_reg      <= cfg_data;
                    CFG_TCO:      tco_coef_reg      <= cfg_data;
                    CFG_TREF:     tref_coef_reg     <= cfg_data;
                    CFG_TEMPSENS: tempsens_coef_reg <= cfg_data;
                    CFG_RATIO:    temp_ratio_reg    <= cfg_data[RATIO_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.load)
                count_reg <= (count_reg == CNT_MAX) ? CNT_W'(1) : count_reg + 1'b1;
            if (cmd.dt_load && sampled)
                held_reg <= rawt_reg;
        end
    end

    // count modulo ratio, two restoring steps per cycle
    assign ratio_eff = (temp_ratio_reg == '0) ? RATIO_W'(1) : temp_ratio_reg;

    always_comb
    begin
        r1  = {rem_reg, mcnt_reg[CNT_W-1]};
        r1s = (r1 >= {1'b0, ratio_eff}) ? r1 - {1'b0, ratio_eff} : r1;
        r2  = {r1s[RATIO_W-1:0], mcnt_reg[CNT_W-2]};
        r2s = (r2 >= {1'b0, ratio_eff}) ? r2 - {1'b0, ratio_eff} : r2;
    end

    assign sampled = (rem_reg == '0);
    assign dt_src  = sampled ? rawt_reg : held_reg;
    assign dt_val  = $signed({1'b0, dt_src}) - $signed({1'b0, tref_coef_reg, {TREF_SH{1'b0}}});

    // shared multiplier operands
    assign a_val = TCOMP_W'(temp_reg) - TCOMP_W'(T_REF);
    assign b_val = TCOMP_W'(temp_reg) - TCOMP_W'(T_COLD);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_TCO:
            begin
                mul_a = $signed({{(MUL_W-COEF_W){1'b0}}, tco_coef_reg});
                mul_b = MUL_W'(dt_reg);
            end
            MUL_TCS:
            begin
                mul_a = $signed({{(MUL_W-COEF_W){1'b0}}, tcs_coef_reg});
                mul_b = MUL_W'(dt_reg);
            end
            MUL_TSENS:
            begin
                mul_a = $signed({{(MUL_W-COEF_W){1'b0}}, tempsens_coef_reg});
                mul_b = MUL_W'(dt_reg);
            end
            MUL_DTSQ:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'(dt_reg);
            end
            MUL_ASQ:
            begin
                mul_a = MUL_W'(a_val);
                mul_b = MUL_W'(a_val);
            end
            MUL_BSQ:
            begin
                mul_a = MUL_W'(b_val);
                mul_b = MUL_W'(b_val);
            end
            MUL_PLO:
            begin
                mul_a = $signed({{(MUL_W-RAW_W){1'b0}}, d1_reg});
                mul_b = $signed({{(MUL_W-SLO_W){1'b0}}, sens_reg[SLO_W-1:0]});
            end
            MUL_PHI:
            begin
                mul_a = $signed({{(MUL_W-RAW_W){1'b0}}, d1_reg});
                mul_b = MUL_W'($signed(sens_reg[SENS_W-1:SLO_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // second-order terms
    assign warm  = (temp_reg >= TEMP_W'(T_REF));
    assign cold  = (temp_reg < TEMP_W'(T_COLD));
    assign bsq   = prod_reg[BSQ_W-1:0];
    assign asq61 = {asq_reg, 6'b0} - {asq_reg, 1'b0} - A61_W'(asq_reg);
    assign bsq15 = {bsq, 4'b0} - B15_W'(bsq);

    always_comb
    begin
        off2_val  = OFF2_W'(asq61[A61_W-1:OFF2_SH]);
        sens2_val = SENS2_W'({asq_reg, 1'b0});
        if (cold)
        begin
            off2_val  = off2_val + OFF2_W'(bsq15);
            sens2_val = sens2_val + SENS2_W'({bsq, 3'b0});
        end
    end

    // checks and final temperature clamp
    assign press = PRESS_W'(pdiff_reg >>> PRESS_SH);
    assign t_ok  = (temp_reg > TEMP_W'(T_LOW)) && (temp_reg < TEMP_W'(T_HIGH));
    assign p_ok  = (press > PRESS_W'(0)) && (press < PRESS_W'(P_HIGH));

    always_comb
    begin
        tsat = tcomp_reg;
        if (tcomp_reg < TCOMP_W'(T_LOW))
            tsat = TCOMP_W'(T_LOW);
        else if (tcomp_reg > TCOMP_W'(T_HIGH))
            tsat = TCOMP_W'(T_HIGH);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d1_reg   <= raw_pressure;
            rawt_reg <= raw_temperature;
            mcnt_reg <= count_reg;
            rem_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= r2s[RATIO_W-1:0];
            mcnt_reg <= {mcnt_reg[CNT_W-3:0], 2'b00};
        end
        if (cmd.dt_load)
        begin
            dt_reg   <= dt_val;
            samp_reg <= sampled;
        end

        prod_reg <= mul_p;

        unique case (cmd.acc_op)
            ACC_OFF:
                off_reg <= $signed({{(OFF_W-COEF_W-OFF_BASE_SH){1'b0}}, off_coef_reg,
                                    {OFF_BASE_SH{1'b0}}})
                           + OFF_W'(prod_reg >>> OFF_SH);
            ACC_SENS:
                sens_reg <= $signed({{(SENS_W-COEF_W-SENS_BASE_SH){1'b0}}, sens_coef_reg,
                                     {SENS_BASE_SH{1'b0}}})
                            + SENS_W'(prod_reg >>> SENS_SH);
            ACC_TEMP:
                temp_reg <= TEMP_W'(prod_reg >>> TEMP_SH) + TEMP_W'(T_REF);
            ACC_T2:
                t2_reg <= prod_reg[T2_SH +: T2_W];
            ACC_ASQ:
                asq_reg <= prod_reg[ASQ_W-1:0];
            ACC_PLO:
                plo_reg <= prod_reg[PLO_W-1:0];
            ACC_PSUM:
                psum_reg <= (PSUM_W'(prod_reg) <<< SLO_W) + PSUM_W'(plo_reg);
            default: ;
        endcase

        if (cmd.corr_calc)
        begin
            if (warm)
            begin
                off2_reg  <= '0;
                sens2_reg <= '0;
                tcomp_reg <= TCOMP_W'(temp_reg);
            end
            else
            begin
                off2_reg  <= off2_val;
                sens2_reg <= sens2_val;
                tcomp_reg <= TCOMP_W'(temp_reg) - $signed({2'b00, t2_reg});
            end
        end
        if (cmd.corr_apply)
        begin
            off_reg  <= off_reg - $signed({{(OFF_W-OFF2_W){1'b0}}, off2_reg});
            sens_reg <= sens_reg - $signed({{(SENS_W-SENS2_W){1'b0}}, sens2_reg});
        end
        if (cmd.pdiff_load)
            pdiff_reg <= PDIFF_W'(psum_reg >>> PSUM_SH) - PDIFF_W'(off_reg);

        if (cmd.out_load)
        begin
            samp_out_reg <= samp_reg;
            if (!t_ok)
            begin
                err_reg  <= ERR_TEMP;
                tout_reg <= '0;
                pout_reg <= '0;
            end
            else if (!p_ok)
            begin
                err_reg  <= ERR_PRESS;
                tout_reg <= '0;
                pout_reg <= '0;
            end
            else
            begin
                err_reg  <= ERR_OK;
                tout_reg <= TOUT_W'(tsat);
                pout_reg <= press[POUT_W-1:0];
            end
        end
    end

    assign temperature  = tout_reg;
    assign pressure     = pout_reg;
    assign valid_res    = (err_reg == ERR_OK);
    assign error_code   = err_reg;
    assign temp_sampled = samp_out_reg;

endmodule

`default_nettype wire

// File: design/baro_sensor_compensation_top.sv
`timescale 1ns / 1ps
`default_nettype none

// barometric sensor compensation: each input beat carries a raw pressure and a
// raw temperature conversion; every temp_ratio-th beat (by an 8-bit measurement
// count) refreshes the held raw temperature. from the held temperature and the
// six calibration words the block forms dT, OFF, SENS and the first-order
// temperature, applies the second-order correction below 20.00 C (extra term
// below -15.00 C) and computes pressure. one result beat per input beat gives
// temperature in centidegrees, pressure in pascals, a valid flag and an error
// code; a failed range check zeroes both values. a sequencer steps each item
// through the modulo of the count, dT, eight products through one shared
// 26x26 multiplier (each product registered before use), the second-order
// correction, the pressure sum and difference, and the result load; the next
// input beat is taken in the cycle after the load. the result sits in an output
// register, so a new input beat is taken while the previous result waits; only
// a result that is still stalled when the next one is ready holds the sequencer.
// calibration writes are expected while no item is in flight.

module baro_sensor_compensation_top
    import baro_comp_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    // configuration write port
    input  wire                        cfg_wr_en,
    input  wire  [IDX_W-1:0]           cfg_index,
    input  wire  [COEF_W-1:0]          cfg_data,
    // input channel
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  [RAW_W-1:0]           raw_pressure,
    input  wire  [RAW_W-1:0]           raw_temperature,
    // output channel
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic signed [TOUT_W-1:0]   temperature,
    output logic [POUT_W-1:0]          pressure,
    output logic                       valid_res,
    output logic [ERR_W-1:0]           error_code,
    output logic                       temp_sampled
);

    // command bundle from the sequencer to the datapath
    cmd_t cmd;

    // sequencer: step control and output beat handshake
    baro_comp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: calibration registers, shared multiplier, result register
    baro_comp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .temperature     (temperature),
        .pressure        (pressure),
        .valid_res       (valid_res),
        .error_code      (error_code),
        .temp_sampled    (temp_sampled)
    );

    // an accepted beat starts the sequence, so the input side closes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // valid flag and error code agree
    a_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (error_code == ERR_OK))
        else $error("valid result with nonzero error code");

    // a failed check reads zero and carries an error
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |->
            (temperature == '0 && pressure == '0 && error_code != ERR_OK))
        else $error("invalid result with nonzero values");

    // a valid result lies within the checked ranges
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |->
            (temperature >= TOUT_W'(T_LOW) && temperature <= TOUT_W'(T_HIGH)
             && pressure != '0))
        else $error("valid result out of range");

endmodule

`default_nettype wire
